/* src/vjm_pkg.sv */
// Types and constants shared by the voltage jump monitor modules.
package vjm_pkg;

   localparam int DEV_W     = 5;
   localparam int READ_W    = 16;
   localparam int CNT_W     = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_W     = 16;
   localparam int DIFF_W    = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD    = 8'd1;

   localparam logic [CSR_W-1:0] THRESHOLD_RESET = 16'd30;
   localparam logic [CSR_W-1:0] PERIOD_RESET    = 16'd21 + 16'd9;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      logic [DEV_W-1:0]         device_number;
      logic signed [READ_W-1:0] reading;
   } req_type;

   typedef struct packed {
      logic             warning;
      logic             report_valid;
      logic [DEV_W-1:0] worst_device;
   } rsp_type;

endpackage

/* src/voltage_jump_monitor_top.sv */
// Top level of the voltage jump monitor: sequencer, state stores and result register.
//
// One reading is accepted when req_ready is high; the block then works on it alone.
// An in-range reading that does not close a report period passes these steps before
// the next acceptance: fetch of the stored reading and counter from the per-device
// RAMs, difference, threshold check with write-back, result load. A reading that
// closes a period adds a scan, in which the warning counter RAM is read one entry a
// cycle through its single read port and the shared subtractor picks the largest
// count. A reading for a device number at or above DEVICE_COUNT goes straight to the
// result load. Results wait in an output register, so a new reading is taken while
// the last result still waits. Per-device valid flops stand for the all-zero reset
// state, so no clearing pass is needed after reset.
module voltage_jump_monitor_top
   import vjm_pkg::*;
#(
   parameter int DEVICE_COUNT = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(DEVICE_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEVICE_COUNT - 1);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_FETCH     = 7'b0000010,
      ST_DIFF      = 7'b0000100,
      ST_CHECK     = 7'b0001000,
      ST_SCAN      = 7'b0010000,
      ST_SCAN_LAST = 7'b0100000,
      ST_FINISH    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [CSR_W-1:0] threshold_ff, threshold_in;
   logic [CSR_W-1:0] period_ff, period_in;
   logic [CNT_W-1:0] rip_ff, rip_in;

   logic [IDX_W-1:0]         dev_ff, dev_in;
   logic signed [READ_W-1:0] rd_ff, rd_in;
   logic                     prev_nz_ff, prev_nz_in;
   logic [DIFF_W-2:0]        mag_ff, mag_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     warn_ff, warn_in;
   logic                     rep_ff, rep_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [CNT_W-1:0]         best_cnt_ff, best_cnt_in;

   logic [DEVICE_COUNT-1:0] vld_ff, vld_in;
   logic                    rd_vld_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]  raddr;
   logic              we;
   logic [READ_W-1:0] last_q;
   logic [CNT_W-1:0]  cnt_q;
   logic [CNT_W-1:0]  cnt_wdata;
   logic signed [READ_W-1:0] prev;
   logic [CNT_W-1:0]  cnt_rd;

   logic signed [DIFF_W-1:0] sub_a, sub_b, sub_diff;
   logic                     sub_neg;
   logic [DIFF_W-2:0]        abs_diff;

   logic [CNT_W-1:0] rip_next;
   logic [CSR_W-1:0] period_eff;
   logic             dev_in_range;
   logic             out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dev_in_range = (32'(req_data.device_number) < DEVICE_COUNT);
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // Select the RAM read address: scan index while scanning, else the device
   assign raddr = (state_ff == ST_SCAN) ? scan_ff : dev_ff;
   assign we    = (state_ff == ST_CHECK);

   // Stored values read as zero until the entry is first written
   assign prev   = rd_vld_ff ? signed'(last_q) : '0;
   assign cnt_rd = rd_vld_ff ? cnt_q : '0;

   assign cnt_wdata = (warn_in && cnt_ff != CNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;

   vjm_ram #(
      .WIDTH(READ_W),
      .DEPTH(DEVICE_COUNT)
   ) u_last_ram (
      .clock (clock),
      .we    (we),
      .waddr (dev_ff),
      .wdata (rd_ff),
      .raddr (raddr),
      .rdata (last_q)
   );

   vjm_ram #(
      .WIDTH(CNT_W),
      .DEPTH(DEVICE_COUNT)
   ) u_count_ram (
      .clock (clock),
      .we    (we),
      .waddr (dev_ff),
      .wdata (cnt_wdata),
      .raddr (raddr),
      .rdata (cnt_q)
   );

   // Steer the shared subtractor by sequencer step
   always_comb begin
      case (state_ff)
         ST_DIFF: begin
            sub_a = DIFF_W'(rd_ff);
            sub_b = DIFF_W'(prev);
         end
         ST_CHECK: begin
            sub_a = signed'({2'b00, threshold_ff});
            sub_b = signed'({1'b0, mag_ff});
         end
         default: begin
            sub_a = signed'({2'b00, best_cnt_ff});
            sub_b = signed'({2'b00, cnt_rd});
         end
      endcase
   end

   vjm_sub_unit u_sub (
      .a    (sub_a),
      .b    (sub_b),
      .diff (sub_diff),
      .neg  (sub_neg)
   );

   assign abs_diff   = sub_neg ? (DIFF_W-1)'(-sub_diff) : sub_diff[DIFF_W-2:0];
   assign rip_next   = rip_ff + 1'b1;
   assign period_eff = (period_ff == '0) ? CSR_W'(1) : period_ff;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      threshold_in = threshold_ff;
      period_in    = period_ff;
      rip_in       = rip_ff;
      dev_in       = dev_ff;
      rd_in        = rd_ff;
      prev_nz_in   = prev_nz_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      warn_in      = warn_ff;
      rep_in       = rep_ff;
      scan_in      = scan_ff;
      best_idx_in  = best_idx_ff;
      best_cnt_in  = best_cnt_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Take configuration writes; unknown indexes are dropped
      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_data;
            CSR_PERIOD:    period_in    = csr_data;
            default: ;
         endcase
      end

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dev_in  = IDX_W'(req_data.device_number);
               rd_in   = req_data.reading;
               warn_in = 1'b0;
               rep_in  = 1'b0;
               state_in = dev_in_range ? ST_FETCH : ST_FINISH;
            end
         end
         ST_FETCH: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            prev_nz_in = (prev != '0);
            mag_in     = abs_diff;
            cnt_in     = cnt_rd;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            warn_in        = prev_nz_ff && sub_neg;
            vld_in[dev_ff] = 1'b1;
            best_idx_in    = '0;
            best_cnt_in    = '0;
            scan_in        = '0;
            if (rip_next >= period_eff) begin
               rip_in   = '0;
               rep_in   = 1'b1;
               state_in = ST_SCAN;
            end else begin
               rip_in   = rip_next;
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            // Data on the read port belongs to the previous index
            if (scan_ff != '0 && sub_neg) begin
               best_idx_in = scan_ff - 1'b1;
               best_cnt_in = cnt_rd;
            end
            if (scan_ff == LAST_IDX) begin
               state_in = ST_SCAN_LAST;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_SCAN_LAST: begin
            if (sub_neg) begin
               best_idx_in = LAST_IDX;
               best_cnt_in = cnt_rd;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.warning       = warn_ff;
               rsp_data_in.report_valid  = rep_ff;
               rsp_data_in.worst_device  = rep_ff ? DEV_W'(best_idx_ff) : '0;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= THRESHOLD_RESET;
         period_ff    <= PERIOD_RESET;
         rip_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         period_ff    <= period_in;
         rip_ff       <= rip_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dev_ff      <= dev_in;
      rd_ff       <= rd_in;
      prev_nz_ff  <= prev_nz_in;
      mag_ff      <= mag_in;
      cnt_ff      <= cnt_in;
      warn_ff     <= warn_in;
      rep_ff      <= rep_in;
      scan_ff     <= scan_in;
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
      rd_vld_ff   <= vld_ff[raddr];
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* src/vjm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vjm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, register the read word every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/vjm_sub_unit.sv */
// Shared signed subtractor used for the reading difference and all compares.
module vjm_sub_unit
   import vjm_pkg::*;
(
   input  logic signed [DIFF_W-1:0] a,
   input  logic signed [DIFF_W-1:0] b,
   output logic signed [DIFF_W-1:0] diff,
   output logic                     neg
);

   // Subtract; the sign tells b > a
   assign diff = a - b;
   assign neg  = diff[DIFF_W-1];

endmodule
